// ----- sv/rdvt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdvt_pkg
// Shared types and constants for the distance-vector route table.
// ----------------------------------------------------------------------------
package rdvt_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int PORT_COUNT_DEF  = 4;
    localparam int MAX_RESULTS     = 32;
    localparam int METRIC_W        = 5;
    localparam int AGE_W           = 8;
    localparam int PORT_W          = 2;
    localparam int ADDR_W          = 32;

    localparam logic [METRIC_W-1:0] RESET_INFINITY = 5'd16;
    localparam logic [AGE_W-1:0]    RESET_TIMEOUT  = 8'd20;
    localparam logic [AGE_W-1:0]    AGE_CEIL       = 8'd255;

    // configuration register indexes
    localparam logic CFG_INFINITY = 1'b0;
    localparam logic CFG_TIMEOUT  = 1'b1;

    typedef enum logic [1:0] {
        t_OP_ROUTE = 2'd0,
        t_OP_TICK  = 2'd1,
        t_OP_IFACE = 2'd2,
        t_OP_DUMP  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_APPEND,
        S_EMIT,
        S_DONE
    } t_state;

    // one table row as stored in the RAM
    typedef struct packed {
        logic [ADDR_W-1:0]   dest;
        logic [ADDR_W-1:0]   mask;
        logic [ADDR_W-1:0]   gateway;
        logic [PORT_W-1:0]   port;
        logic [METRIC_W-1:0] metric;
        logic [AGE_W-1:0]    age;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // decision of the row update unit
    typedef struct packed {
        logic   wr;       // row rewritten
        logic   changed;  // counts as a table change
        logic   found;    // row matched the prefix
        logic   emit;     // dump lists this row
        t_entry row;
    } t_upd;

endpackage

// ----- sv/rdvt_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdvt_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module rdvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/rdvt_row_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdvt_row_unit
// Shared row evaluator: one table row per use, for every opcode.
// ----------------------------------------------------------------------------
module rdvt_row_unit (
    input  rdvt_pkg::t_opcode                 i_op,
    input  logic                              i_up,
    input  logic [rdvt_pkg::ADDR_W-1:0]       i_addr,
    input  logic [rdvt_pkg::ADDR_W-1:0]       i_pmask,
    input  logic [rdvt_pkg::ADDR_W-1:0]       i_sender,
    input  logic [rdvt_pkg::PORT_W-1:0]       i_port,
    input  logic [rdvt_pkg::METRIC_W-1:0]     i_new_metric,
    input  logic [rdvt_pkg::METRIC_W-1:0]     i_inf,
    input  logic [rdvt_pkg::AGE_W-1:0]        i_timeout,
    input  rdvt_pkg::t_entry                  i_row,
    output rdvt_pkg::t_upd                    o_upd
);
    import rdvt_pkg::*;

    logic               pfx_match;
    logic [AGE_W-1:0]   age_inc;

    assign pfx_match = (i_row.dest & i_row.mask) == (i_addr & i_pmask);
    assign age_inc   = (i_row.age < AGE_CEIL) ? i_row.age + 8'd1 : i_row.age;

    always_comb begin
        o_upd     = '0;
        o_upd.row = i_row;
        case (i_op)
            t_OP_ROUTE: begin
                if (pfx_match) begin
                    o_upd.found = 1'b1;
                    if (i_row.port == i_port && i_row.gateway == i_sender) begin
                        o_upd.wr         = 1'b1;
                        o_upd.row.age    = '0;
                        o_upd.row.metric = i_new_metric;
                        o_upd.changed    = i_row.metric != i_new_metric;
                    end else if (i_new_metric < i_row.metric) begin
                        o_upd.wr          = 1'b1;
                        o_upd.changed     = 1'b1;
                        o_upd.row.dest    = i_addr;
                        o_upd.row.mask    = i_pmask;
                        o_upd.row.gateway = i_sender;
                        o_upd.row.port    = i_port;
                        o_upd.row.metric  = i_new_metric;
                        o_upd.row.age     = '0;
                    end
                end
            end
            t_OP_TICK: begin
                o_upd.wr      = 1'b1;
                o_upd.row.age = age_inc;
                if (age_inc > i_timeout && i_row.metric != i_inf) begin
                    o_upd.row.metric = i_inf;
                    o_upd.changed    = 1'b1;
                end
            end
            t_OP_IFACE: begin
                if (!i_up) begin
                    if (i_row.port == i_port && i_row.metric != i_inf) begin
                        o_upd.wr         = 1'b1;
                        o_upd.changed    = 1'b1;
                        o_upd.row.metric = i_inf;
                    end
                end else if (i_row.mask == i_pmask && pfx_match) begin
                    o_upd.wr          = 1'b1;
                    o_upd.changed     = 1'b1;
                    o_upd.found       = 1'b1;
                    o_upd.row.age     = '0;
                    o_upd.row.gateway = '0;
                    o_upd.row.port    = i_port;
                    o_upd.row.metric  = '0;
                end
            end
            t_OP_DUMP: begin
                o_upd.emit = i_row.port != i_port;
            end
            default: begin
                o_upd.wr = 1'b0;
            end
        endcase
    end
endmodule

// ----- sv/rip_distance_vector_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rip_distance_vector_table_top
// Bounded RIP routing table: merges route entries, ages routes on ticks,
// handles interface events and dumps routes with split horizon.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                Content
// s_axis    in   s_axis_tvalid/tready     one command item
// m_axis    out  m_axis_tvalid/tready     result items, tlast on the final one
// cfg       in   i_cfg_valid/o_cfg_ready  register index and data
//
// Rows are kept in one RAM and walked by a sequencer: each row passes a read
// state and an evaluate/write state through the shared row unit, and a route
// that qualifies for a dump adds an emit state that waits out any output
// stall. The input stays busy until the walk, the append and the final item
// are done. A dump holds each listed route back until the next one is
// found or the scan ends, so the final route can carry tlast.
// Input is not taken while an item is in progress. Reset clears the count,
// the sequencer and the flags and loads the configuration defaults; row
// contents need no clearing because rows beyond the count are never evaluated.
// ----------------------------------------------------------------------------
module rip_distance_vector_table_top #(
    parameter int TABLE_DEPTH = rdvt_pkg::TABLE_DEPTH_DEF,
    parameter int PORT_COUNT  = rdvt_pkg::PORT_COUNT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: entry_used[0], prefix_address[32:1], prefix_mask[64:33],
    //   advertised_metric[69:65], sender_address[101:70], port_index[103:102],
    //   port_up[104], zero fill up to 111
    input  logic [111:0] s_axis_tdata,
    // tuser: opcode[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: route_valid[0], route_dest[32:1], route_mask[64:33],
    //   route_next_hop[96:65], route_metric[101:97], table_changed[102],
    //   table_full[103]
    output logic [103:0] m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [7:0]   i_cfg_data
);
    import rdvt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int RES_W = $clog2(MAX_RESULTS + 1);

    // configuration
    logic [METRIC_W-1:0] r_inf;
    logic [AGE_W-1:0]    r_timeout;

    // command fields held for the whole item
    t_opcode             r_op;
    logic                r_used, r_up;
    logic [ADDR_W-1:0]   r_addr, r_pmask, r_sender;
    logic [PORT_W-1:0]   r_port;
    logic [METRIC_W-1:0] r_new_metric;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count;    // rows in use
    logic [CNT_W-1:0]    r_idx;      // row being walked
    logic [RES_W-1:0]    r_nres;     // dump routes listed
    logic                r_changed, r_full, r_found;

    // output register
    logic                r_ovalid, r_olast;
    logic [103:0]        r_odata;

    // dump route waiting for its successor or the end of the scan
    logic                r_pend;
    logic [103:0]        r_pend_data;

    t_entry              ram_rdata, ram_wdata;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_addr;
    t_upd                upd;

    logic [METRIC_W:0]   adv_inc;
    logic                port_bad;
    logic                in_fire, out_free, out_load;
    logic                need_append;
    t_entry              app_row;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;

    // a new result item enters the output register
    assign out_load = out_free &&
                      ((r_state == S_EMIT && r_pend && r_nres < RES_W'(MAX_RESULTS)) ||
                       r_state == S_DONE);

    assign adv_inc  = {1'b0, s_axis_tdata[69:65]} + 6'd1;
    assign port_bad = {30'd0, s_axis_tdata[103:102]} >= 32'(PORT_COUNT);

    rdvt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    rdvt_row_unit u_row (
        .i_op         (r_op),
        .i_up         (r_up),
        .i_addr       (r_addr),
        .i_pmask      (r_pmask),
        .i_sender     (r_sender),
        .i_port       (r_port),
        .i_new_metric (r_new_metric),
        .i_inf        (r_inf),
        .i_timeout    (r_timeout),
        .i_row        (ram_rdata),
        .o_upd        (upd)
    );

    // Appends: a route entry with no match below infinity, or an up event
    // with no matching subnet.
    always_comb begin
        need_append = 1'b0;
        app_row     = '0;
        if (r_op == t_OP_ROUTE && r_used && !r_found && r_new_metric != r_inf) begin
            need_append     = 1'b1;
            app_row.dest    = r_addr;
            app_row.mask    = r_pmask;
            app_row.gateway = r_sender;
            app_row.port    = r_port;
            app_row.metric  = r_new_metric;
        end else if (r_op == t_OP_IFACE && r_up && !r_found) begin
            need_append  = 1'b1;
            app_row.dest = r_addr & r_pmask;
            app_row.mask = r_pmask;
            app_row.port = r_port;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (port_bad || (s_axis_tuser == t_OP_ROUTE && !s_axis_tdata[0]))
                        n_state = S_DONE;
                    else
                        n_state = S_READ;
                end
            end
            S_READ: begin
                if (r_idx >= r_count)
                    n_state = S_APPEND;
                else
                    n_state = S_EVAL;
            end
            S_EVAL: begin
                if (r_op == t_OP_DUMP && upd.emit) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_READ;
                end
            end
            S_EMIT: begin
                if (out_free) n_state = S_READ;
            end
            S_APPEND: n_state = S_DONE;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // RAM controls
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_idx[IDX_W-1:0];
        ram_wdata = upd.row;
        case (r_state)
            S_EVAL: begin
                ram_we = upd.wr;
                ram_addr = IDX_W'(r_idx - CNT_W'(1));
            end
            S_EMIT: begin
                // keep the listed row on the read port while stalled
                ram_addr = IDX_W'(r_idx - CNT_W'(1));
            end
            S_APPEND: begin
                ram_we    = need_append && (r_count < CNT_W'(TABLE_DEPTH));
                ram_wdata = app_row;
                ram_addr  = r_count[IDX_W-1:0];
            end
            default: ram_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_nres    <= '0;
            r_changed <= 1'b0;
            r_full    <= 1'b0;
            r_found   <= 1'b0;
            r_ovalid  <= 1'b0;
            r_olast   <= 1'b0;
            r_pend    <= 1'b0;
            r_inf     <= RESET_INFINITY;
            r_timeout <= RESET_TIMEOUT;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_INFINITY: r_inf     <= i_cfg_data[METRIC_W-1:0];
                    CFG_TIMEOUT:  r_timeout <= i_cfg_data;
                    default:      r_inf     <= r_inf;
                endcase
            end
            if (out_load)
                r_ovalid <= 1'b1;
            else if (m_axis_tready)
                r_ovalid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    r_idx     <= '0;
                    r_nres    <= '0;
                    r_changed <= 1'b0;
                    r_full    <= 1'b0;
                    r_found   <= 1'b0;
                    r_pend    <= 1'b0;
                end
                S_READ: begin
                    if (r_idx < r_count) r_idx <= r_idx + CNT_W'(1);
                end
                S_EVAL: begin
                    if (upd.changed) r_changed <= 1'b1;
                    if (upd.found)   r_found   <= 1'b1;
                end
                S_EMIT: begin
                    if (out_free && r_nres < RES_W'(MAX_RESULTS)) begin
                        // send the held route, hold this one
                        if (r_pend) begin
                            r_olast <= 1'b0;
                            r_odata <= r_pend_data;
                        end
                        r_pend      <= 1'b1;
                        r_pend_data <= {2'b00, ram_rdata.metric, ram_rdata.gateway,
                                        ram_rdata.mask, ram_rdata.dest, 1'b1};
                        r_nres      <= r_nres + RES_W'(1);
                    end
                end
                S_APPEND: begin
                    if (need_append) begin
                        if (r_count < CNT_W'(TABLE_DEPTH)) begin
                            r_count   <= r_count + CNT_W'(1);
                            r_changed <= 1'b1;
                        end else begin
                            r_full <= 1'b1;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        // final item: the held dump route, else the status item
                        r_olast <= 1'b1;
                        r_odata <= r_pend ? r_pend_data : {r_full, r_changed, 102'd0};
                    end
                end
                default: r_idx <= r_idx;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op         <= t_opcode'(s_axis_tuser);
            r_used       <= s_axis_tdata[0];
            r_addr       <= s_axis_tdata[32:1];
            r_pmask      <= s_axis_tdata[64:33];
            r_sender     <= s_axis_tdata[101:70];
            r_port       <= s_axis_tdata[103:102];
            r_up         <= s_axis_tdata[104];
            r_new_metric <= (adv_inc >= {1'b0, r_inf}) ? r_inf : adv_inc[METRIC_W-1:0];
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = r_odata;
endmodule
